// File: design/assert_macros.svh
// Assertion macros used by the peer recency table datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define PRT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the same cycle, outside reset.
`define PRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/prt_pkg.sv
// Types and constants shared by the peer recency table modules.
package prt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int COUNT_W = 7;
    localparam int CFG_IDX_W = 8;

    localparam logic [63:0] DEFAULT_TTL_MS = 64'd604800000;
    localparam logic [COUNT_W-1:0] DEFAULT_CAPACITY = 7'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_TO_LIVE_MS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY_LIMIT = 8'd1;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic        action;
        logic [7:0]  id_type;
        logic [63:0] device_id;
        logic [63:0] now_ms;
        logic        time_valid;
    } t_prt_in_req;

    typedef struct packed {
        logic               key_found;
        logic               recently_synced;
        logic               evicted;
        logic [COUNT_W-1:0] entry_count;
    } t_prt_out_rsp;

    typedef struct packed {
        logic        valid;
        logic [7:0]  id_type;
        logic [63:0] device_id;
        logic [63:0] time_ms;
    } t_prt_entry;

    typedef struct packed {
        logic clear;
        logic start;
        logic scan;
        logic commit_a;
        logic commit_b;
        logic finish;
    } t_prt_cmd;

    typedef struct packed {
        logic addr_last;
        logic need_b;
        logic out_free;
    } t_prt_sts;

endpackage

// File: design/prt_ctrl.sv
// Controller state machine of the peer recency table.
module prt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  prt_pkg::t_prt_sts i_sts,
    output prt_pkg::t_prt_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_DRAIN    = 7'b0001000,
        S_COMMIT   = 7'b0010000,
        S_COMMIT_B = 7'b0100000,
        S_OUT      = 7'b1000000
    } t_prt_state;

    t_prt_state r_state;
    t_prt_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit_a = 1'b1;
                n_state = i_sts.need_b ? S_COMMIT_B : S_OUT;
            end
            S_COMMIT_B: begin
                o_cmd.commit_b = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// File: design/prt_dp.sv
// Datapath of the peer recency table: entry memory, scan trackers and result register.
`include "assert_macros.svh"

module prt_dp #(
    parameter int TABLE_DEPTH = prt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  prt_pkg::t_prt_cmd                   i_cmd,
    output prt_pkg::t_prt_sts                   o_sts,
    input  prt_pkg::t_prt_in_req                i_in_req,
    input  logic                                i_cfg_valid,
    input  logic [prt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [63:0]                         i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output prt_pkg::t_prt_out_rsp               o_out_rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = (CW > prt_pkg::COUNT_W) ? CW : prt_pkg::COUNT_W;

    prt_pkg::t_prt_entry r_mem [TABLE_DEPTH];
    prt_pkg::t_prt_entry r_rd;
    logic                r_rd_vld;
    logic [AW-1:0]       r_rd_slot;
    logic [AW-1:0]       r_addr;

    prt_pkg::t_prt_in_req r_req;

    logic          r_hit;
    logic [AW-1:0] r_hit_slot;
    logic [63:0]   r_hit_time;
    logic          r_old_valid;
    logic [AW-1:0] r_old_slot;
    logic [63:0]   r_old_time;
    logic          r_free_valid;
    logic [AW-1:0] r_free_slot;

    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic [63:0]                 r_ttl;
    logic [prt_pkg::COUNT_W-1:0] r_cap;
    logic                        r_evict;
    logic                        r_ge;
    logic [63:0]                 r_diff;

    logic                  r_out_valid;
    prt_pkg::t_prt_out_rsp r_out_rsp;
    prt_pkg::t_prt_out_rsp n_out_rsp;

    logic                        key_match;
    logic                        older;
    logic [prt_pkg::COUNT_W-1:0] cap_eff;
    logic                        full;
    logic                        do_rec;
    logic                        insert;
    logic                        free_lower;
    logic [AW-1:0]               ins_slot;
    logic [64:0]                 age;

    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    prt_pkg::t_prt_entry mem_wd;

    assign key_match = r_rd.valid && (r_rd.id_type == r_req.id_type)
                       && (r_rd.device_id == r_req.device_id);
    assign older = !r_old_valid || (r_rd.time_ms < r_old_time);
    assign cap_eff = (r_cap == '0) ? prt_pkg::COUNT_W'(1) : r_cap;
    assign full = (KW'(r_count) >= KW'(TABLE_DEPTH)) || (KW'(r_count) >= KW'(cap_eff));
    assign do_rec = (r_req.action == prt_pkg::ACT_RECORD) && r_req.time_valid;
    assign insert = do_rec && !r_hit;
    assign free_lower = r_free_valid && (r_free_slot < r_old_slot);
    assign ins_slot = full ? (free_lower ? r_free_slot : r_old_slot) : r_free_slot;
    assign age = {1'b0, r_req.now_ms} - {1'b0, r_hit_time};

    assign o_sts.addr_last = (r_addr == AW'(TABLE_DEPTH - 1));
    assign o_sts.need_b = insert && full && free_lower;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = '0;
        priority if (i_cmd.clear) begin
            mem_we = 1'b1;
        end else if (i_cmd.commit_a && do_rec) begin
            mem_we = 1'b1;
            mem_wa = r_hit ? r_hit_slot : ins_slot;
            mem_wd.valid = 1'b1;
            mem_wd.id_type = r_req.id_type;
            mem_wd.device_id = r_req.device_id;
            mem_wd.time_ms = r_req.now_ms;
        end else if (i_cmd.commit_b) begin
            mem_we = 1'b1;
            mem_wa = r_old_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.scan) begin
            r_rd <= r_mem[r_addr];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.commit_a && insert && !full) begin
            n_count = CW'(r_count + 1'b1);
        end
    end

    always_comb begin
        n_out_rsp.key_found = r_hit;
        n_out_rsp.recently_synced = (r_req.action == prt_pkg::ACT_QUERY) && r_hit
                                    && r_req.time_valid && r_ge && (r_diff < r_ttl);
        n_out_rsp.evicted = r_evict;
        n_out_rsp.entry_count = prt_pkg::COUNT_W'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_rd_vld <= 1'b0;
            r_count <= '0;
            r_ttl <= prt_pkg::DEFAULT_TTL_MS;
            r_cap <= prt_pkg::DEFAULT_CAPACITY;
            r_out_valid <= 1'b0;
            r_hit <= 1'b0;
            r_old_valid <= 1'b0;
            r_free_valid <= 1'b0;
            r_evict <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan;
            r_count <= n_count;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    prt_pkg::CFG_TIME_TO_LIVE_MS: r_ttl <= i_cfg_data;
                    prt_pkg::CFG_CAPACITY_LIMIT: r_cap <= i_cfg_data[prt_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clear || i_cmd.scan) begin
                r_addr <= AW'(r_addr + 1'b1);
            end else if (i_cmd.start) begin
                r_addr <= '0;
            end
            if (i_cmd.start) begin
                r_hit <= 1'b0;
                r_old_valid <= 1'b0;
                r_free_valid <= 1'b0;
                r_evict <= 1'b0;
            end else if (r_rd_vld) begin
                if (key_match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (r_rd.valid && older) begin
                    r_old_valid <= 1'b1;
                end
                if (!r_rd.valid && !r_free_valid) begin
                    r_free_valid <= 1'b1;
                end
            end else if (i_cmd.commit_a) begin
                r_evict <= insert && full;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req <= i_in_req;
        end
        if (i_cmd.scan) begin
            r_rd_slot <= r_addr;
        end
        if (r_rd_vld) begin
            if (key_match && !r_hit) begin
                r_hit_slot <= r_rd_slot;
                r_hit_time <= r_rd.time_ms;
            end
            if (r_rd.valid && older) begin
                r_old_slot <= r_rd_slot;
                r_old_time <= r_rd.time_ms;
            end
            if (!r_rd.valid && !r_free_valid) begin
                r_free_slot <= r_rd_slot;
            end
        end
        if (i_cmd.commit_a) begin
            r_ge <= !age[64];
            r_diff <= age[63:0];
        end
        if (i_cmd.finish) begin
            r_out_rsp <= n_out_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp = r_out_rsp;

    `PRT_ASSERT(a_count_bound, i_clk, i_rst_n, KW'(r_count) <= KW'(TABLE_DEPTH), "count above depth")
    `PRT_ASSERT_IMP(a_second_write_evicts, i_clk, i_rst_n, i_cmd.commit_b, r_evict && r_old_valid, "second write without eviction")
    `PRT_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, i_cmd.finish, !r_out_valid || i_out_ready, "result overwritten")

endmodule

// File: design/peer_recency_table_top.sv
// Top level of the peer recency table: controller, datapath and port wiring.
//
// The block keeps up to TABLE_DEPTH peer keys with their last sync time and answers
// one result for every request. Each request walks the whole entry memory once, one
// entry per cycle through its single read port, to find the key, the oldest entry and
// the lowest free slot. A drain step and the commit follow, with a second write that
// clears the evicted entry when a new key evicts one from a higher slot than the free
// slot it fills; the result is loaded once the output register is free. The controller
// is idle as it loads, so a new request is accepted while that result waits to be taken.
// After reset the memory is cleared entry by entry before the first request is accepted;
// configuration writes are accepted only while the block is idle and ready for a request.
module peer_recency_table_top #(
    parameter int TABLE_DEPTH = prt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  prt_pkg::t_prt_in_req          i_in_req,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output prt_pkg::t_prt_out_rsp         o_out_rsp,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [prt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data
);

    prt_pkg::t_prt_cmd cmd;
    prt_pkg::t_prt_sts sts;

    assign o_cfg_ready = o_in_ready;

    prt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    prt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_req    (i_in_req),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

endmodule
